### rtl/esp_pkg.sv
// Shared types, widths and constants of the ellipse support point core.
`timescale 1ns / 1ps
`default_nettype none

package esp_pkg;

    // Width of a normalized magnitude, top bit at position 29.
    localparam int NORM_W = 30;
    // Product of a radius (31 bits) with a normalized magnitude.
    localparam int PROD_W = 61;
    // Radicand of the norm: sum of two squares of NORM_W bits.
    localparam int SQ_IN_W = 61;
    // Root and quotient width.
    localparam int ROOT_W = 31;
    // Dividend: radius product plus half the norm.
    localparam int DIVD_W = 62;

    localparam int CORDIC_STEPS = 30;
    localparam int CORDIC_W = 34;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_INV = 34'sd652032874;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_ANGLE = 3'd4;

    typedef struct packed {
        logic deg;
        logic neg_x;
        logic neg_y;
        logic zero;
    } esp_side_t;

    typedef struct packed {
        esp_side_t           side;
        logic [PROD_W-1:0]   prod_x;
        logic [PROD_W-1:0]   prod_y;
    } esp_sqtag_t;

    // Arctangent of 2^-i in units of 2^-32 turn.
    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] val;
        begin
            case (idx)
                5'd0:    val = 32'h20000000;
                5'd1:    val = 32'h12E4051E;
                5'd2:    val = 32'h09FB385B;
                5'd3:    val = 32'h051111D4;
                5'd4:    val = 32'h028B0D43;
                5'd5:    val = 32'h0145D7E1;
                5'd6:    val = 32'h00A2F61E;
                5'd7:    val = 32'h00517C55;
                5'd8:    val = 32'h0028BE53;
                5'd9:    val = 32'h00145F2F;
                5'd10:   val = 32'h000A2F98;
                5'd11:   val = 32'h000517CC;
                5'd12:   val = 32'h00028BE6;
                5'd13:   val = 32'h000145F3;
                5'd14:   val = 32'h0000A2FA;
                5'd15:   val = 32'h0000517D;
                5'd16:   val = 32'h000028BE;
                5'd17:   val = 32'h0000145F;
                5'd18:   val = 32'h00000A30;
                5'd19:   val = 32'h00000518;
                5'd20:   val = 32'h0000028C;
                5'd21:   val = 32'h00000146;
                5'd22:   val = 32'h000000A3;
                5'd23:   val = 32'h00000051;
                5'd24:   val = 32'h00000029;
                5'd25:   val = 32'h00000014;
                5'd26:   val = 32'h0000000A;
                5'd27:   val = 32'h00000005;
                5'd28:   val = 32'h00000003;
                5'd29:   val = 32'h00000001;
                default: val = 32'h00000000;
            endcase
            return val;
        end
    endfunction

endpackage

`default_nettype wire

### rtl/ellipse_support_point_core.sv
// Top level: support point of a rotated ellipse, configuration registers and pipeline.
// The pipeline has 78 register stages from an accepted input transaction to its output,
// most of them in the 31-stage square root and the 31-stage divider.
// Throughput: one direction per cycle; the whole pipeline stalls while the output waits.
// A turn_angle write runs a 30-step CORDIC and holds both ports off until the run is done.
// Reset (asynchronous, active low) clears valid bits and loads the default configuration.
`timescale 1ns / 1ps
`default_nettype none

module ellipse_support_point_core
    import esp_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int TRIG_BITS = 18
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [31:0]   dir_x,
    input  logic signed [31:0]   dir_y,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [31:0]   point_x,
    output logic signed [31:0]   point_y,
    output logic                 degenerate,
    output logic                 saturated
);

    localparam int PW = 32 + TRIG_BITS;
    localparam int XW = PW + 1;
    localparam int WW = XW + 1;
    localparam int SW = WW + 1;
    localparam int RS = TRIG_BITS - 2;
    localparam logic [XW:0] RHALF = (XW + 1)'(1) << (RS - 1);
    localparam logic [63:0] DEG_LIMIT =
        64'(((64'd1 << (2 * FRAC_BITS)) - 64'd1) / 64'd1000000000000);
    localparam logic signed [SW-1:0] SAT_MAX = SW'(64'sd2147483647);
    localparam logic signed [SW-1:0] SAT_MIN = SW'(-64'sd2147483648);

    // Configuration.
    logic signed [31:0] center_x_reg, center_y_reg;
    logic [30:0] radius_x_reg, radius_y_reg;
    logic cfg_fire, busy, angle_start;
    logic signed [TRIG_BITS-1:0] rot_cos, rot_sin;

    logic en;

    assign cfg_ready = !busy;
    assign cfg_fire = cfg_valid && cfg_ready;
    assign angle_start = cfg_fire && (cfg_index == CFG_TURN_ANGLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            radius_x_reg <= 31'd65536;
            radius_y_reg <= 31'd65536;
        end
        else if (cfg_fire)
        begin
            unique case (cfg_index)
                CFG_CENTER_X: center_x_reg <= cfg_data;
                CFG_CENTER_Y: center_y_reg <= cfg_data;
                CFG_RADIUS_X: radius_x_reg <= cfg_data[30:0];
                CFG_RADIUS_Y: radius_y_reg <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    esp_cordic #(
        .TRIG_BITS(TRIG_BITS)
    ) u_cordic (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (angle_start),
        .angle  (cfg_data[15:0]),
        .busy   (busy),
        .rot_cos(rot_cos),
        .rot_sin(rot_sin)
    );

    // The whole pipeline moves whenever the output register is free or being taken.
    assign en = !out_valid || out_ready;
    assign in_ready = en && !busy;

    // Stage 1: input capture.
    logic v1_reg;
    logic signed [31:0] dx1_reg, dy1_reg;

    // Stage 2: turn products and near-zero test.
    logic v2_reg;
    logic signed [PW-1:0] p_xc_reg, p_ys_reg, p_xs_reg, p_yc_reg;
    logic deg2_reg, deg2_next;
    logic [31:0] mx, my;
    logic [32:0] sq_small;

    always_comb
    begin
        mx = dx1_reg[31] ? 32'(-dx1_reg) : 32'(dx1_reg);
        my = dy1_reg[31] ? 32'(-dy1_reg) : 32'(dy1_reg);
        sq_small = 33'(mx[15:0]) * 33'(mx[15:0]) + 33'(my[15:0]) * 33'(my[15:0]);
        deg2_next = (mx[31:16] == '0) && (my[31:16] == '0) && (64'(sq_small) <= DEG_LIMIT);
    end

    // Stage 3: direction in the ellipse frame, split into sign and magnitude.
    logic v3_reg;
    logic [XW-1:0] ux3_reg, uy3_reg;
    esp_side_t side3_reg, side3_next;
    logic signed [XW-1:0] xr, yr;

    always_comb
    begin
        xr = XW'(p_xc_reg) + XW'(p_ys_reg);
        yr = XW'(p_yc_reg) - XW'(p_xs_reg);
        side3_next.deg = deg2_reg;
        side3_next.neg_x = xr[XW-1];
        side3_next.neg_y = yr[XW-1];
        side3_next.zero = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid && !busy;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx1_reg <= dir_x;
            dy1_reg <= dir_y;
            p_xc_reg <= PW'(dx1_reg) * PW'(rot_cos);
            p_ys_reg <= PW'(dy1_reg) * PW'(rot_sin);
            p_xs_reg <= PW'(dx1_reg) * PW'(rot_sin);
            p_yc_reg <= PW'(dy1_reg) * PW'(rot_cos);
            deg2_reg <= deg2_next;
            ux3_reg <= xr[XW-1] ? XW'(-xr) : XW'(xr);
            uy3_reg <= yr[XW-1] ? XW'(-yr) : XW'(yr);
            side3_reg <= side3_next;
        end
    end

    // First normalization of the direction magnitudes.
    logic n1_vld;
    logic [NORM_W-1:0] n1_x, n1_y;
    esp_side_t n1_side;

    esp_norm #(
        .IN_W (XW),
        .TAG_W($bits(esp_side_t))
    ) u_norm_dir (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .in_vld (v3_reg),
        .in_p   (ux3_reg),
        .in_q   (uy3_reg),
        .in_tag (side3_reg),
        .out_vld(n1_vld),
        .out_p  (n1_x),
        .out_q  (n1_y),
        .out_tag(n1_side)
    );

    // Stage 4: scale by the radii.
    logic v4_reg;
    logic [PROD_W-1:0] aa4_reg, bb4_reg;
    esp_side_t side4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v4_reg <= n1_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            aa4_reg <= PROD_W'(radius_x_reg) * PROD_W'(n1_x);
            bb4_reg <= PROD_W'(radius_y_reg) * PROD_W'(n1_y);
            side4_reg <= n1_side;
        end
    end

    logic n2_vld;
    logic [NORM_W-1:0] n2_a, n2_b;
    esp_side_t n2_side;

    esp_norm #(
        .IN_W (PROD_W),
        .TAG_W($bits(esp_side_t))
    ) u_norm_scaled (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .in_vld (v4_reg),
        .in_p   (aa4_reg),
        .in_q   (bb4_reg),
        .in_tag (side4_reg),
        .out_vld(n2_vld),
        .out_p  (n2_a),
        .out_q  (n2_b),
        .out_tag(n2_side)
    );

    // Stage 5: squares and the numerator products. Stage 6: sum of squares.
    logic v5_reg, v6_reg;
    logic [2*NORM_W-1:0] sqa5_reg, sqb5_reg;
    logic [PROD_W-1:0] prx5_reg, pry5_reg;
    esp_side_t side5_reg, side5_next;
    logic [SQ_IN_W-1:0] sum6_reg;
    esp_sqtag_t tag6_reg;

    always_comb
    begin
        side5_next = n2_side;
        side5_next.zero = (n2_a == '0) && (n2_b == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (en)
        begin
            v5_reg <= n2_vld;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqa5_reg <= (2 * NORM_W)'(n2_a) * (2 * NORM_W)'(n2_a);
            sqb5_reg <= (2 * NORM_W)'(n2_b) * (2 * NORM_W)'(n2_b);
            prx5_reg <= PROD_W'(radius_x_reg) * PROD_W'(n2_a);
            pry5_reg <= PROD_W'(radius_y_reg) * PROD_W'(n2_b);
            side5_reg <= side5_next;
            sum6_reg <= SQ_IN_W'(sqa5_reg) + SQ_IN_W'(sqb5_reg);
            tag6_reg.side <= side5_reg;
            tag6_reg.prod_x <= prx5_reg;
            tag6_reg.prod_y <= pry5_reg;
        end
    end

    logic sq_vld;
    logic [ROOT_W-1:0] sq_root;
    esp_sqtag_t sq_tag;

    esp_sqrt #(
        .TAG_W($bits(esp_sqtag_t))
    ) u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (v6_reg),
        .in_rad  (sum6_reg),
        .in_tag  (tag6_reg),
        .out_vld (sq_vld),
        .out_root(sq_root),
        .out_tag (sq_tag)
    );

    // Stage 7: dividends with half the norm added for rounding.
    logic v7_reg;
    logic [DIVD_W-1:0] numx7_reg, numy7_reg;
    logic [ROOT_W-1:0] den7_reg;
    esp_side_t side7_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v7_reg <= 1'b0;
        end
        else if (en)
        begin
            v7_reg <= sq_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            numx7_reg <= DIVD_W'(sq_tag.prod_x) + DIVD_W'(sq_root >> 1);
            numy7_reg <= DIVD_W'(sq_tag.prod_y) + DIVD_W'(sq_root >> 1);
            den7_reg <= sq_root;
            side7_reg <= sq_tag.side;
        end
    end

    logic dv_vld;
    logic [ROOT_W-1:0] quo_x, quo_y;
    esp_side_t dv_side;

    esp_div #(
        .TAG_W($bits(esp_side_t))
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (v7_reg),
        .in_num_x (numx7_reg),
        .in_num_y (numy7_reg),
        .in_den   (den7_reg),
        .in_tag   (side7_reg),
        .out_vld  (dv_vld),
        .out_quo_x(quo_x),
        .out_quo_y(quo_y),
        .out_tag  (dv_side)
    );

    // Stage 8: signed local point. Stage 9: turn-back products.
    // Stage 10: turn-back sums. Stage 11: rounding.
    logic v8_reg, v9_reg, v10_reg, v11_reg;
    logic signed [31:0] px8_reg, py8_reg;
    logic signed [31:0] qxs, qys;
    logic signed [PW-1:0] b_xc9_reg, b_ys9_reg, b_xs9_reg, b_yc9_reg;
    logic signed [XW-1:0] wx10_reg, wy10_reg;
    logic signed [WW-1:0] wx11_reg, wy11_reg;
    logic deg8_reg, deg9_reg, deg10_reg, deg11_reg;

    function automatic logic signed [WW-1:0] round_away(input logic signed [XW-1:0] v);
        logic [XW:0] mag, r;
        begin
            mag = (XW + 1)'(v[XW-1] ? XW'(-v) : XW'(v));
            r = (mag + RHALF) >> RS;
            return v[XW-1] ? WW'(-$signed(r)) : WW'($signed(r));
        end
    endfunction

    always_comb
    begin
        qxs = $signed({1'b0, quo_x});
        qys = $signed({1'b0, quo_y});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v8_reg <= 1'b0;
            v9_reg <= 1'b0;
            v10_reg <= 1'b0;
            v11_reg <= 1'b0;
        end
        else if (en)
        begin
            v8_reg <= dv_vld;
            v9_reg <= v8_reg;
            v10_reg <= v9_reg;
            v11_reg <= v10_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (dv_side.zero)
            begin
                px8_reg <= '0;
                py8_reg <= '0;
            end
            else
            begin
                px8_reg <= dv_side.neg_x ? -qxs : qxs;
                py8_reg <= dv_side.neg_y ? -qys : qys;
            end
            deg8_reg <= dv_side.deg;
            b_xc9_reg <= PW'(px8_reg) * PW'(rot_cos);
            b_ys9_reg <= PW'(py8_reg) * PW'(rot_sin);
            b_xs9_reg <= PW'(px8_reg) * PW'(rot_sin);
            b_yc9_reg <= PW'(py8_reg) * PW'(rot_cos);
            deg9_reg <= deg8_reg;
            wx10_reg <= XW'(b_xc9_reg) - XW'(b_ys9_reg);
            wy10_reg <= XW'(b_xs9_reg) + XW'(b_yc9_reg);
            deg10_reg <= deg9_reg;
            wx11_reg <= round_away(wx10_reg);
            wy11_reg <= round_away(wy10_reg);
            deg11_reg <= deg10_reg;
        end
    end

    // Stage 12: add the center, or give the fallback point, and saturate.
    logic out_valid_reg, degenerate_reg, saturated_reg, sat_x, sat_y;
    logic signed [31:0] point_x_reg, point_y_reg, pxo, pyo;
    logic signed [SW-1:0] sum_x, sum_y, rad_x_s;

    always_comb
    begin
        rad_x_s = $signed(SW'({1'b0, radius_x_reg}));
        if (deg11_reg)
        begin
            sum_x = SW'(center_x_reg) + rad_x_s;
            sum_y = SW'(center_y_reg);
        end
        else
        begin
            sum_x = SW'(center_x_reg) + SW'(wx11_reg);
            sum_y = SW'(center_y_reg) + SW'(wy11_reg);
        end
        sat_x = (sum_x > SAT_MAX) || (sum_x < SAT_MIN);
        sat_y = (sum_y > SAT_MAX) || (sum_y < SAT_MIN);
        pxo = (sum_x > SAT_MAX) ? 32'sh7FFFFFFF :
              (sum_x < SAT_MIN) ? 32'sh80000000 : 32'(sum_x);
        pyo = (sum_y > SAT_MAX) ? 32'sh7FFFFFFF :
              (sum_y < SAT_MIN) ? 32'sh80000000 : 32'(sum_y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= v11_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            point_x_reg <= pxo;
            point_y_reg <= pyo;
            degenerate_reg <= deg11_reg;
            saturated_reg <= sat_x || sat_y;
        end
    end

    assign out_valid = out_valid_reg;
    assign point_x = point_x_reg;
    assign point_y = point_y_reg;
    assign degenerate = degenerate_reg;
    assign saturated = saturated_reg;

    // A CORDIC run blocks both the configuration port and the input.
    assert property (@(posedge clk) disable iff (!rst_n) !cfg_ready |-> !in_ready)
        else $error("input accepted while rotation update runs");

    // The fallback point keeps the center's y coordinate.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> point_y == center_y_reg)
        else $error("fallback point has wrong y");

    // A saturated result has at least one coordinate at a range limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |->
            (point_x == 32'sh7FFFFFFF) || (point_x == 32'sh80000000) ||
            (point_y == 32'sh7FFFFFFF) || (point_y == 32'sh80000000))
        else $error("saturation flag without a clipped coordinate");

endmodule

`default_nettype wire

### rtl/esp_cordic.sv
// Iterative CORDIC that turns a written angle into the rotation cosine and sine.
`timescale 1ns / 1ps
`default_nettype none

module esp_cordic
    import esp_pkg::*;
#(
    parameter int TRIG_BITS = 18
)(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [15:0]                 angle,
    output logic                        busy,
    output logic signed [TRIG_BITS-1:0] rot_cos,
    output logic signed [TRIG_BITS-1:0] rot_sin
);

    localparam int RS = 32 - TRIG_BITS;
    localparam logic signed [CORDIC_W-1:0] QTR_TURN = 34'sd1073741824;
    localparam logic signed [CORDIC_W-1:0] HALF_TURN = 34'sd2147483648;
    localparam logic signed [CORDIC_W-1:0] RHALF = CORDIC_W'(1) <<< (RS - 1);
    localparam logic signed [CORDIC_W-1:0] ONE_C = CORDIC_W'(1) <<< (TRIG_BITS - 2);
    localparam logic [4:0] LAST_STEP = 5'(CORDIC_STEPS - 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } cordic_state_t;

    cordic_state_t state_reg, state_next;
    logic [4:0] step_reg, step_next;
    logic signed [CORDIC_W-1:0] x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic neg_reg, neg_next;
    logic signed [TRIG_BITS-1:0] cos_reg, cos_next, sin_reg, sin_next;

    logic signed [CORDIC_W-1:0] z_init, atan_v, xf, yf;

    function automatic logic signed [TRIG_BITS-1:0] round_clamp(
        input logic signed [CORDIC_W-1:0] v
    );
        logic signed [CORDIC_W-1:0] mag, r, s;
        begin
            mag = (v < 0) ? -v : v;
            r = (mag + RHALF) >>> RS;
            s = (v < 0) ? -r : r;
            if (s > ONE_C) begin
                s = ONE_C;
            end
            if (s < -ONE_C) begin
                s = -ONE_C;
            end
            return TRIG_BITS'(s);
        end
    endfunction

    always_comb
    begin
        state_next = state_reg;
        step_next = step_reg;
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        neg_next = neg_reg;
        cos_next = cos_reg;
        sin_next = sin_reg;
        z_init = CORDIC_W'($signed({angle, 16'h0000}));
        atan_v = CORDIC_W'(atan_turn(step_reg));
        xf = neg_reg ? -x_reg : x_reg;
        yf = neg_reg ? -y_reg : y_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    x_next = CORDIC_GAIN_INV;
                    y_next = '0;
                    step_next = '0;
                    // Fold the angle into the right half plane.
                    if (z_init > QTR_TURN)
                    begin
                        z_next = z_init - HALF_TURN;
                        neg_next = 1'b1;
                    end
                    else if (z_init < -QTR_TURN)
                    begin
                        z_next = z_init + HALF_TURN;
                        neg_next = 1'b1;
                    end
                    else
                    begin
                        z_next = z_init;
                        neg_next = 1'b0;
                    end
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (z_reg >= 0)
                begin
                    x_next = x_reg - (y_reg >>> step_reg);
                    y_next = y_reg + (x_reg >>> step_reg);
                    z_next = z_reg - atan_v;
                end
                else
                begin
                    x_next = x_reg + (y_reg >>> step_reg);
                    y_next = y_reg - (x_reg >>> step_reg);
                    z_next = z_reg + atan_v;
                end
                step_next = step_reg + 5'd1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                cos_next = round_clamp(xf);
                sin_next = round_clamp(yf);
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cos_reg <= TRIG_BITS'(ONE_C);
            sin_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cos_reg <= cos_next;
            sin_reg <= sin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        neg_reg <= neg_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign rot_cos = cos_reg;
    assign rot_sin = sin_reg;

endmodule

`default_nettype wire

### rtl/esp_norm.sv
// Two-stage pair normalizer: leading-one search, then a joint shift that brings the larger into [2^29, 2^30).
`timescale 1ns / 1ps
`default_nettype none

module esp_norm
    import esp_pkg::*;
#(
    parameter int IN_W = 51,
    parameter int TAG_W = 4
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_vld,
    input  logic [IN_W-1:0]   in_p,
    input  logic [IN_W-1:0]   in_q,
    input  logic [TAG_W-1:0]  in_tag,
    output logic              out_vld,
    output logic [NORM_W-1:0] out_p,
    output logic [NORM_W-1:0] out_q,
    output logic [TAG_W-1:0]  out_tag
);

    localparam int LW = $clog2(IN_W);
    localparam logic [LW-1:0] TARGET = LW'(NORM_W - 1);

    logic [IN_W-1:0] both;
    logic [LW-1:0] lead_next;

    logic vld_a_reg, vld_b_reg;
    logic [IN_W-1:0] p_a_reg, q_a_reg;
    logic [LW-1:0] lead_a_reg;
    logic [TAG_W-1:0] tag_a_reg, tag_b_reg;
    logic [NORM_W-1:0] p_b_reg, q_b_reg, p_b_next, q_b_next;

    logic [LW-1:0] rsh, lsh;
    logic [IN_W-1:0] p_r, q_r;

    // The larger of the pair has the same leading one as their OR.
    always_comb
    begin
        both = in_p | in_q;
        lead_next = '0;
        for (int i = 0; i < IN_W; i++)
        begin
            if (both[i])
            begin
                lead_next = LW'(i);
            end
        end
    end

    always_comb
    begin
        rsh = lead_a_reg - TARGET;
        lsh = TARGET - lead_a_reg;
        p_r = p_a_reg >> rsh;
        q_r = q_a_reg >> rsh;
        if (lead_a_reg > TARGET)
        begin
            p_b_next = p_r[NORM_W-1:0];
            q_b_next = q_r[NORM_W-1:0];
        end
        else
        begin
            p_b_next = p_a_reg[NORM_W-1:0] << lsh;
            q_b_next = q_a_reg[NORM_W-1:0] << lsh;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_a_reg <= in_vld;
            vld_b_reg <= vld_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_a_reg <= in_p;
            q_a_reg <= in_q;
            lead_a_reg <= lead_next;
            tag_a_reg <= in_tag;
            p_b_reg <= p_b_next;
            q_b_reg <= q_b_next;
            tag_b_reg <= tag_a_reg;
        end
    end

    assign out_vld = vld_b_reg;
    assign out_p = p_b_reg;
    assign out_q = q_b_reg;
    assign out_tag = tag_b_reg;

endmodule

`default_nettype wire

### rtl/esp_sqrt.sv
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module esp_sqrt
    import esp_pkg::*;
#(
    parameter int TAG_W = 8
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_vld,
    input  logic [SQ_IN_W-1:0] in_rad,
    input  logic [TAG_W-1:0]   in_tag,
    output logic               out_vld,
    output logic [ROOT_W-1:0]  out_root,
    output logic [TAG_W-1:0]   out_tag
);

    localparam int TW = SQ_IN_W + 2;

    logic [ROOT_W-1:0] vld_reg;
    logic [SQ_IN_W-1:0] rem_reg [ROOT_W-1];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [TAG_W-1:0] tag_reg [ROOT_W];

    for (genvar j = 0; j < ROOT_W; j++)
    begin : g_stage
        localparam int K = ROOT_W - 1 - j;
        logic vld_in;
        logic [SQ_IN_W-1:0] rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [TAG_W-1:0] tag_in;
        logic [TW-1:0] trial;
        logic take;

        if (j == 0)
        begin : g_first
            assign vld_in = in_vld;
            assign rem_in = in_rad;
            assign root_in = '0;
            assign tag_in = in_tag;
        end
        else
        begin : g_next
            assign vld_in = vld_reg[j-1];
            assign rem_in = rem_reg[j-1];
            assign root_in = root_reg[j-1];
            assign tag_in = tag_reg[j-1];
        end

        // Root holds no bits at or below K, so the OR is the sum 2^(K+1)r + 4^K.
        assign trial = (TW'(root_in) << (K + 1)) | (TW'(1) << (2 * K));
        assign take = (TW'(rem_in) >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[j] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_reg[j] <= take ? (root_in | (ROOT_W'(1) << K)) : root_in;
                tag_reg[j] <= tag_in;
            end
        end

        if (j < ROOT_W - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[j] <= take ? (rem_in - trial[SQ_IN_W-1:0]) : rem_in;
                end
            end
        end
    end

    assign out_vld = vld_reg[ROOT_W-1];
    assign out_root = root_reg[ROOT_W-1];
    assign out_tag = tag_reg[ROOT_W-1];

endmodule

`default_nettype wire

### rtl/esp_div.sv
// Pipelined two-lane restoring divider with a shared divisor, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module esp_div
    import esp_pkg::*;
#(
    parameter int TAG_W = 4
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_vld,
    input  logic [DIVD_W-1:0] in_num_x,
    input  logic [DIVD_W-1:0] in_num_y,
    input  logic [ROOT_W-1:0] in_den,
    input  logic [TAG_W-1:0]  in_tag,
    output logic              out_vld,
    output logic [ROOT_W-1:0] out_quo_x,
    output logic [ROOT_W-1:0] out_quo_y,
    output logic [TAG_W-1:0]  out_tag
);

    logic [ROOT_W-1:0] vld_reg;
    logic [DIVD_W-1:0] rx_reg [ROOT_W-1];
    logic [DIVD_W-1:0] ry_reg [ROOT_W-1];
    logic [ROOT_W-1:0] den_reg [ROOT_W-1];
    logic [ROOT_W-1:0] qx_reg [ROOT_W];
    logic [ROOT_W-1:0] qy_reg [ROOT_W];
    logic [TAG_W-1:0] tag_reg [ROOT_W];

    // The quotient is known to fit in ROOT_W bits, so the top stage starts at 2^(ROOT_W-1).
    for (genvar j = 0; j < ROOT_W; j++)
    begin : g_stage
        localparam int K = ROOT_W - 1 - j;
        logic vld_in;
        logic [DIVD_W-1:0] rx_in, ry_in, trial;
        logic [ROOT_W-1:0] den_in, qx_in, qy_in;
        logic [TAG_W-1:0] tag_in;
        logic take_x, take_y;

        if (j == 0)
        begin : g_first
            assign vld_in = in_vld;
            assign rx_in = in_num_x;
            assign ry_in = in_num_y;
            assign den_in = in_den;
            assign qx_in = '0;
            assign qy_in = '0;
            assign tag_in = in_tag;
        end
        else
        begin : g_next
            assign vld_in = vld_reg[j-1];
            assign rx_in = rx_reg[j-1];
            assign ry_in = ry_reg[j-1];
            assign den_in = den_reg[j-1];
            assign qx_in = qx_reg[j-1];
            assign qy_in = qy_reg[j-1];
            assign tag_in = tag_reg[j-1];
        end

        assign trial = DIVD_W'(den_in) << K;
        assign take_x = (rx_in >= trial);
        assign take_y = (ry_in >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[j] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                qx_reg[j] <= take_x ? (qx_in | (ROOT_W'(1) << K)) : qx_in;
                qy_reg[j] <= take_y ? (qy_in | (ROOT_W'(1) << K)) : qy_in;
                tag_reg[j] <= tag_in;
            end
        end

        if (j < ROOT_W - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rx_reg[j] <= take_x ? (rx_in - trial) : rx_in;
                    ry_reg[j] <= take_y ? (ry_in - trial) : ry_in;
                    den_reg[j] <= den_in;
                end
            end
        end
    end

    assign out_vld = vld_reg[ROOT_W-1];
    assign out_quo_x = qx_reg[ROOT_W-1];
    assign out_quo_y = qy_reg[ROOT_W-1];
    assign out_tag = tag_reg[ROOT_W-1];

endmodule

`default_nettype wire
